### design/sit_pkg.sv
`timescale 1ns / 1ps
package sit_pkg;

    localparam int CoordBits = 16;
    localparam int PointBits = 32;
    // quotient bits kept after the overflow check (values below 2^33)
    localparam int QuoBits   = 33;
    localparam int DiffBits  = CoordBits + 1;
    localparam int ProdBits  = 2 * DiffBits;
    localparam int DenBits   = ProdBits + 1;
    localparam int NumBits   = CoordBits + DenBits + 2;

    typedef enum logic [1:0] {
        CLASS_NONE      = 2'd0,
        CLASS_BOUNDED   = 2'd1,
        CLASS_UNBOUNDED = 2'd2
    } t_class;

    typedef struct packed {
        logic signed [CoordBits-1:0] first_start_x;
        logic signed [CoordBits-1:0] first_start_y;
        logic signed [CoordBits-1:0] first_end_x;
        logic signed [CoordBits-1:0] first_end_y;
        logic signed [CoordBits-1:0] second_start_x;
        logic signed [CoordBits-1:0] second_start_y;
        logic signed [CoordBits-1:0] second_end_x;
        logic signed [CoordBits-1:0] second_end_y;
    } t_seg_word;

    typedef struct packed {
        t_class                      crossing_class;
        logic                        point_valid;
        logic signed [PointBits-1:0] point_x;
        logic signed [PointBits-1:0] point_y;
        logic                        point_saturated;
    } t_isect_word;

    // side info that travels next to the divider lanes
    typedef struct packed {
        logic   vld;
        logic   parallel;
        t_class cls;
        logic   x_neg;
        logic   y_neg;
        logic   x_ovf;
        logic   y_ovf;
    } t_meta;

endpackage

### design/sit_front.sv
`timescale 1ns / 1ps
module sit_front #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_en,
    input  logic                                   i_valid,
    input  sit_pkg::t_seg_word                     i_seg,
    output sit_pkg::t_meta                         o_meta,
    output logic [sit_pkg::NumBits+FRAC_BITS-1:0]  o_x_mag,
    output logic [sit_pkg::NumBits+FRAC_BITS-1:0]  o_y_mag,
    output logic [sit_pkg::DenBits-1:0]            o_dv
);
    localparam int C   = sit_pkg::CoordBits;
    localparam int DIF = sit_pkg::DiffBits;
    localparam int PRD = sit_pkg::ProdBits;
    localparam int DEN = sit_pkg::DenBits;
    localparam int NUM = sit_pkg::NumBits;
    localparam int SW  = NUM + FRAC_BITS;
    localparam int QB  = sit_pkg::QuoBits;

    logic [5:0] r_vld;

    // stage 1: differences
    logic signed [C-1:0]   r1_p1x, r1_p1y;
    logic signed [DIF-1:0] r1_ax, r1_ay, r1_bx, r1_by, r1_cx, r1_cy;
    // stage 2: cross products
    logic signed [C-1:0]   r2_p1x, r2_p1y;
    logic signed [DIF-1:0] r2_ax, r2_ay;
    logic signed [PRD-1:0] r2_aybx, r2_axby, r2_bycx, r2_bxcy, r2_axcy, r2_aycx;
    // stage 3: denominator and numerators
    logic signed [C-1:0]   r3_p1x, r3_p1y;
    logic signed [DIF-1:0] r3_ax, r3_ay;
    logic signed [DEN-1:0] r3_d, r3_na, r3_nb;
    // stage 4: point products, class
    logic signed [C+DEN-1:0]   r4_bdx, r4_bdy;
    logic signed [DIF+DEN-1:0] r4_anx, r4_any;
    logic [DEN-1:0]            r4_dv;
    logic                      r4_dneg, r4_par;
    sit_pkg::t_class           r4_cls;
    // stage 5: dividend magnitude
    logic [NUM-1:0]  r5_magx, r5_magy;
    logic            r5_xneg, r5_yneg, r5_par;
    logic [DEN-1:0]  r5_dv;
    sit_pkg::t_class r5_cls;
    // stage 6: scaled dividend and overflow check
    logic [SW-1:0]   r6_shx, r6_shy;
    logic            r6_xneg, r6_yneg, r6_par, r6_xovf, r6_yovf;
    logic [DEN-1:0]  r6_dv;
    sit_pkg::t_class r6_cls;

    logic            n4_dpos, n4_ina, n4_inb;
    logic signed [NUM-1:0] n5_nx, n5_ny;
    logic [SW-1:0]   n6_shx, n6_shy;

    always_comb begin
        n4_dpos = !r3_d[DEN-1];
        n4_ina  = n4_dpos ? (r3_na >= 0 && r3_na <= r3_d) : (r3_na <= 0 && r3_na >= r3_d);
        n4_inb  = n4_dpos ? (r3_nb >= 0 && r3_nb <= r3_d) : (r3_nb <= 0 && r3_nb >= r3_d);
        n5_nx   = NUM'(r4_bdx) + NUM'(r4_anx);
        n5_ny   = NUM'(r4_bdy) + NUM'(r4_any);
        n6_shx  = SW'(r5_magx) << FRAC_BITS;
        n6_shy  = SW'(r5_magy) << FRAC_BITS;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[4:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_p1x  <= i_seg.first_start_x;
            r1_p1y  <= i_seg.first_start_y;
            r1_ax   <= DIF'(i_seg.first_end_x) - DIF'(i_seg.first_start_x);
            r1_ay   <= DIF'(i_seg.first_end_y) - DIF'(i_seg.first_start_y);
            r1_bx   <= DIF'(i_seg.second_start_x) - DIF'(i_seg.second_end_x);
            r1_by   <= DIF'(i_seg.second_start_y) - DIF'(i_seg.second_end_y);
            r1_cx   <= DIF'(i_seg.first_start_x) - DIF'(i_seg.second_start_x);
            r1_cy   <= DIF'(i_seg.first_start_y) - DIF'(i_seg.second_start_y);

            r2_p1x  <= r1_p1x;
            r2_p1y  <= r1_p1y;
            r2_ax   <= r1_ax;
            r2_ay   <= r1_ay;
            r2_aybx <= PRD'(r1_ay) * PRD'(r1_bx);
            r2_axby <= PRD'(r1_ax) * PRD'(r1_by);
            r2_bycx <= PRD'(r1_by) * PRD'(r1_cx);
            r2_bxcy <= PRD'(r1_bx) * PRD'(r1_cy);
            r2_axcy <= PRD'(r1_ax) * PRD'(r1_cy);
            r2_aycx <= PRD'(r1_ay) * PRD'(r1_cx);

            r3_p1x  <= r2_p1x;
            r3_p1y  <= r2_p1y;
            r3_ax   <= r2_ax;
            r3_ay   <= r2_ay;
            r3_d    <= DEN'(r2_aybx) - DEN'(r2_axby);
            r3_na   <= DEN'(r2_bycx) - DEN'(r2_bxcy);
            r3_nb   <= DEN'(r2_axcy) - DEN'(r2_aycx);

            r4_bdx  <= (C+DEN)'(r3_p1x) * (C+DEN)'(r3_d);
            r4_bdy  <= (C+DEN)'(r3_p1y) * (C+DEN)'(r3_d);
            r4_anx  <= (DIF+DEN)'(r3_ax) * (DIF+DEN)'(r3_na);
            r4_any  <= (DIF+DEN)'(r3_ay) * (DIF+DEN)'(r3_na);
            r4_dv   <= r3_d[DEN-1] ? DEN'(-r3_d) : DEN'(r3_d);
            r4_dneg <= r3_d[DEN-1];
            r4_par  <= (r3_d == '0);
            r4_cls  <= (n4_ina && n4_inb) ? sit_pkg::CLASS_BOUNDED : sit_pkg::CLASS_UNBOUNDED;

            r5_magx <= n5_nx[NUM-1] ? NUM'(-n5_nx) : NUM'(n5_nx);
            r5_magy <= n5_ny[NUM-1] ? NUM'(-n5_ny) : NUM'(n5_ny);
            r5_xneg <= n5_nx[NUM-1] ^ r4_dneg;
            r5_yneg <= n5_ny[NUM-1] ^ r4_dneg;
            r5_par  <= r4_par;
            r5_dv   <= r4_dv;
            r5_cls  <= r4_cls;

            // quotient >= 2^QB exactly when the dividend's high part reaches the divisor
            r6_shx  <= n6_shx;
            r6_shy  <= n6_shy;
            r6_xovf <= (n6_shx >> QB) >= SW'(r5_dv);
            r6_yovf <= (n6_shy >> QB) >= SW'(r5_dv);
            r6_xneg <= r5_xneg;
            r6_yneg <= r5_yneg;
            r6_par  <= r5_par;
            r6_dv   <= r5_dv;
            r6_cls  <= r5_cls;
        end
    end

    always_comb begin
        o_meta.vld      = r_vld[5];
        o_meta.parallel = r6_par;
        o_meta.cls      = r6_par ? sit_pkg::CLASS_NONE : r6_cls;
        o_meta.x_neg    = r6_xneg;
        o_meta.y_neg    = r6_yneg;
        o_meta.x_ovf    = r6_xovf;
        o_meta.y_ovf    = r6_yovf;
        o_x_mag         = r6_shx;
        o_y_mag         = r6_shy;
        o_dv            = r6_dv;
    end

endmodule

### design/sit_div.sv
`timescale 1ns / 1ps
module sit_div #(
    parameter int SW = 69
) (
    input  logic                            i_clk,
    input  logic                            i_en,
    input  logic [SW-1:0]                   i_mag,
    input  logic [sit_pkg::DenBits-1:0]     i_dv,
    output logic [sit_pkg::QuoBits-1:0]     o_q
);
    localparam int DW = sit_pkg::DenBits;
    localparam int QB = sit_pkg::QuoBits;
    localparam int HW = SW - QB;

    logic [DW-1:0] r_rem [QB];
    logic [QB-1:0] r_low [QB];
    logic [QB-1:0] r_q   [QB];
    logic [DW-1:0] r_dv  [QB];

    logic [HW+DW-1:0] n_hi_ext;
    logic [DW-1:0]    n_rem0;

    // high part is below the divisor unless the overflow flag is set
    always_comb begin
        n_hi_ext = {{DW{1'b0}}, i_mag[SW-1:QB]};
        n_rem0   = n_hi_ext[DW-1:0];
    end

    // one restoring step per stage, one quotient bit each
    for (genvar k = 0; k < QB; k++) begin : g_step
        logic [DW-1:0] n_rem_in;
        logic [QB-1:0] n_low_in;
        logic [QB-1:0] n_q_in;
        logic [DW-1:0] n_dv_in;
        logic [DW:0]   n_try;
        logic          n_ge;

        if (k == 0) begin : g_first
            always_comb begin
                n_rem_in = n_rem0;
                n_low_in = i_mag[QB-1:0];
                n_q_in   = '0;
                n_dv_in  = i_dv;
            end
        end else begin : g_next
            always_comb begin
                n_rem_in = r_rem[k-1];
                n_low_in = r_low[k-1];
                n_q_in   = r_q[k-1];
                n_dv_in  = r_dv[k-1];
            end
        end

        always_comb begin
            n_try = {n_rem_in, n_low_in[QB-1]};
            n_ge  = n_try >= {1'b0, n_dv_in};
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= n_ge ? DW'(n_try - {1'b0, n_dv_in}) : DW'(n_try);
                r_low[k] <= n_low_in << 1;
                r_q[k]   <= {n_q_in[QB-2:0], n_ge};
                r_dv[k]  <= n_dv_in;
            end
        end
    end

    assign o_q = r_q[QB-1];

endmodule

### design/segment_intersection_test.sv
`timescale 1ns / 1ps
// 40 register stages from input word to result word: 6 geometry, 33 divider, 1 output
// (the clamp is combinational)
// throughput: one word per cycle while the skid is empty; bit-per-stage divider lanes
// reset: synchronous active-low i_rst_n clears all valid bits, output and skid valid too
// no memory, no clearing pass; o_in_ready is high from the first reset edge on
module segment_intersection_test #(
    parameter int FRAC_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  sit_pkg::t_seg_word    i_in_word,
    output logic                  o_in_ready,
    output logic                  o_out_valid,
    output sit_pkg::t_isect_word  o_out_word,
    input  logic                  i_out_ready
);
    localparam int QB = sit_pkg::QuoBits;
    localparam int PB = sit_pkg::PointBits;
    localparam int SW = sit_pkg::NumBits + FRAC_BITS;

    // whole pipeline moves together; it halts only while the skid word is held
    logic n_en;

    sit_pkg::t_meta               n_front_meta;
    logic [SW-1:0]                n_x_mag, n_y_mag;
    logic [sit_pkg::DenBits-1:0]  n_dv;
    logic [QB-1:0]                n_x_q, n_y_q;

    // side info delayed to line up with the divider lanes
    sit_pkg::t_meta r_meta [QB];

    sit_pkg::t_isect_word n_res;
    sit_pkg::t_isect_word r_out, r_skid;
    logic                 r_out_vld, r_skid_vld;
    logic                 n_exit, n_x_sat, n_y_sat;
    logic [PB-1:0]        n_x_val, n_y_val;

    assign n_en       = !r_skid_vld;
    assign o_in_ready = n_en;

    sit_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (n_en),
        .i_valid (i_in_valid),
        .i_seg   (i_in_word),
        .o_meta  (n_front_meta),
        .o_x_mag (n_x_mag),
        .o_y_mag (n_y_mag),
        .o_dv    (n_dv)
    );

    sit_div #(
        .SW (SW)
    ) u_div_x (
        .i_clk (i_clk),
        .i_en  (n_en),
        .i_mag (n_x_mag),
        .i_dv  (n_dv),
        .o_q   (n_x_q)
    );

    sit_div #(
        .SW (SW)
    ) u_div_y (
        .i_clk (i_clk),
        .i_en  (n_en),
        .i_mag (n_y_mag),
        .i_dv  (n_dv),
        .o_q   (n_y_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < QB; k++) begin
                r_meta[k] <= '0;
            end
        end else if (n_en) begin
            r_meta[0] <= n_front_meta;
            for (int k = 1; k < QB; k++) begin
                r_meta[k] <= r_meta[k-1];
            end
        end
    end

    // clamp to the signed 32-bit range, then apply the sign
    function automatic logic [PB:0] f_clamp(input logic neg, input logic ovf,
                                            input logic [QB-1:0] q);
        logic [PB:0] res;
        if (!neg) begin
            if (ovf || q > QB'({1'b0, {(PB-1){1'b1}}})) begin
                res = {1'b1, 1'b0, {(PB-1){1'b1}}};
            end else begin
                res = {1'b0, q[PB-1:0]};
            end
        end else begin
            if (ovf || q > QB'({1'b1, {(PB-1){1'b0}}})) begin
                res = {1'b1, 1'b1, {(PB-1){1'b0}}};
            end else begin
                res = {1'b0, PB'(-q[PB-1:0])};
            end
        end
        return res;
    endfunction

    always_comb begin
        {n_x_sat, n_x_val} = f_clamp(r_meta[QB-1].x_neg, r_meta[QB-1].x_ovf, n_x_q);
        {n_y_sat, n_y_val} = f_clamp(r_meta[QB-1].y_neg, r_meta[QB-1].y_ovf, n_y_q);
        n_res.crossing_class = r_meta[QB-1].cls;
        // parallel lines give an all-zero point
        if (r_meta[QB-1].parallel) begin
            n_res.point_valid     = 1'b0;
            n_res.point_x         = '0;
            n_res.point_y         = '0;
            n_res.point_saturated = 1'b0;
        end else begin
            n_res.point_valid     = 1'b1;
            n_res.point_x         = n_x_val;
            n_res.point_y         = n_y_val;
            n_res.point_saturated = n_x_sat | n_y_sat;
        end
        n_exit = n_en && r_meta[QB-1].vld;
    end

    // output register plus one skid word; the pipeline takes words until the skid fills
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (r_out_vld && i_out_ready) begin
            if (r_skid_vld) begin
                r_out      <= r_skid;
                r_skid_vld <= 1'b0;
            end else begin
                r_out_vld <= n_exit;
                r_out     <= n_res;
            end
        end else if (!r_out_vld) begin
            r_out_vld <= n_exit;
            r_out     <= n_res;
        end else if (n_exit) begin
            r_skid     <= n_res;
            r_skid_vld <= 1'b1;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_word  = r_out;

    // a held skid word always sits behind a waiting output word
    a_skid_behind_out : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_vld |-> r_out_vld)
        else $error("skid word held without output word");

    // skid fills only when the output was stalled
    a_skid_on_stall : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_vld) |-> $past(r_out_vld && !i_out_ready))
        else $error("skid filled without stall");

    // a parallel result carries no point
    a_parallel_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_word.point_valid) |->
            (o_out_word.crossing_class == sit_pkg::CLASS_NONE &&
             o_out_word.point_x == '0 && o_out_word.point_y == '0 &&
             !o_out_word.point_saturated))
        else $error("parallel result with nonzero point");

    // a saturated point has a coordinate at a range limit
    a_sat_limit : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_word.point_saturated) |->
            (o_out_word.point_x == {1'b0, {(PB-1){1'b1}}} ||
             o_out_word.point_x == {1'b1, {(PB-1){1'b0}}} ||
             o_out_word.point_y == {1'b0, {(PB-1){1'b1}}} ||
             o_out_word.point_y == {1'b1, {(PB-1){1'b0}}}))
        else $error("saturation flag without clamped coordinate");

endmodule

### bench/tb.sv
`timescale 1ns / 1ps
module tb;

    localparam int NumRandom   = 650;
    localparam int CalmTail    = 120;      // last words sent with no idling
    localparam int LongHold    = 400;      // receiver hold-off, cycles
    localparam int CycleLimit  = 400000;
    localparam int DrainCycles = 60;
    localparam int FracBitsTb  = 16;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid = 1'b0;
    sit_pkg::t_seg_word   i_in_word = '0;
    logic                 o_in_ready;
    logic                 o_out_valid;
    sit_pkg::t_isect_word o_out_word;
    logic                 i_out_ready = 1'b0;

    segment_intersection_test u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_word   (i_in_word),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .o_out_word  (o_out_word),
        .i_out_ready (i_out_ready)
    );

    // words waiting to be offered, and crossings predicted for accepted words
    sit_pkg::t_seg_word   seg_pending[$];
    sit_pkg::t_isect_word crossing_expected[$];
    int          words_sent = 0;
    int          words_total = 0;
    int          words_seen = 0;
    int          fail_count = 0;
    int          cycle_count = 0;
    bit          hold_done = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // exact crossing test and fixed-point point, wide signed arithmetic
    function automatic logic signed [127:0] unit_test(logic signed [127:0] num,
                                                      logic signed [127:0] den);
        if (den > 0) begin
            return (num >= 0 && num <= den) ? 1 : 0;
        end
        return (num <= 0 && num >= den) ? 1 : 0;
    endfunction

    function automatic logic [31:0] fixed_point(logic signed [127:0] base,
                                                logic signed [127:0] dir,
                                                logic signed [127:0] na,
                                                logic signed [127:0] den,
                                                inout logic sat);
        logic signed [127:0] num;
        logic signed [127:0] quo;
        num = base * den + dir * na;
        quo = (num <<< FracBitsTb) / den;   // truncates toward zero
        if (quo > 128'sd2147483647) begin
            sat = 1'b1;
            return 32'h7FFF_FFFF;
        end
        if (quo < -128'sd2147483648) begin
            sat = 1'b1;
            return 32'h8000_0000;
        end
        return quo[31:0];
    endfunction

    function automatic sit_pkg::t_isect_word predict_crossing(sit_pkg::t_seg_word w);
        logic signed [127:0] p1x, p1y, ax, ay, bx, by, cx, cy, den, na, nb;
        sit_pkg::t_isect_word r;
        logic sat;
        p1x = $signed(w.first_start_x);
        p1y = $signed(w.first_start_y);
        ax  = $signed(w.first_end_x) - p1x;
        ay  = $signed(w.first_end_y) - p1y;
        bx  = $signed(w.second_start_x) - $signed(w.second_end_x);
        by  = $signed(w.second_start_y) - $signed(w.second_end_y);
        cx  = p1x - $signed(w.second_start_x);
        cy  = p1y - $signed(w.second_start_y);
        den = ay * bx - ax * by;
        r   = '0;
        r.crossing_class = sit_pkg::CLASS_NONE;
        if (den == 0) begin
            return r;
        end
        na  = by * cx - bx * cy;
        nb  = ax * cy - ay * cx;
        sat = 1'b0;
        r.crossing_class = (unit_test(na, den) != 0 && unit_test(nb, den) != 0)
                           ? sit_pkg::CLASS_BOUNDED : sit_pkg::CLASS_UNBOUNDED;
        r.point_valid     = 1'b1;
        r.point_x         = fixed_point(p1x, ax, na, den, sat);
        r.point_y         = fixed_point(p1y, ay, na, den, sat);
        r.point_saturated = sat;
        return r;
    endfunction

    function automatic sit_pkg::t_seg_word seg_pair(int p1x, int p1y, int p2x, int p2y,
                                                    int q1x, int q1y, int q2x, int q2y);
        sit_pkg::t_seg_word w;
        w.first_start_x  = p1x[15:0];
        w.first_start_y  = p1y[15:0];
        w.first_end_x    = p2x[15:0];
        w.first_end_y    = p2y[15:0];
        w.second_start_x = q1x[15:0];
        w.second_start_y = q1y[15:0];
        w.second_end_x   = q2x[15:0];
        w.second_end_y   = q2y[15:0];
        return w;
    endfunction

    function automatic int small_coord(int span);
        return int'($urandom_range(2 * span)) - span;
    endfunction

    // random segment pair: mostly shaped so every class and saturation shows up
    function automatic sit_pkg::t_seg_word random_pair();
        sit_pkg::t_seg_word w;
        int kind, x0, y0, dx, dy, k, s;
        kind = $urandom_range(9);
        case (kind)
            0, 1, 2: begin
                w = sit_pkg::t_seg_word'({$urandom, $urandom, $urandom, $urandom});
            end
            3, 4, 5: begin
                s = (kind == 5) ? 3000 : 60;
                w = seg_pair(small_coord(s), small_coord(s), small_coord(s), small_coord(s),
                             small_coord(s), small_coord(s), small_coord(s), small_coord(s));
            end
            6, 7: begin
                // parallel or collinear: second direction is a multiple of the first
                x0 = small_coord(2000);
                y0 = small_coord(2000);
                dx = small_coord(40);
                dy = small_coord(40);
                k  = small_coord(30);
                w  = seg_pair(x0, y0, x0 + dx, y0 + dy, small_coord(2000),
                              small_coord(2000), 0, 0);
                w.second_end_x = w.second_start_x + 16'(k * dx);
                w.second_end_y = w.second_start_y + 16'(k * dy);
            end
            default: begin
                // nearly parallel long lines, far-away crossing point
                x0 = small_coord(30000);
                y0 = small_coord(30000);
                dx = small_coord(32767);
                dy = small_coord(4);
                w  = seg_pair(x0, y0, x0 + dx, y0 + dy, x0 + small_coord(3),
                              y0 + small_coord(3), x0 + dx + small_coord(1),
                              y0 + dy + small_coord(2));
            end
        endcase
        return w;
    endfunction

    // stimulus: directed corners first, then random pairs
    initial begin
        // all extremes, degenerate segments
        seg_pending.push_back(seg_pair(-32768, -32768, -32768, -32768,
                                       -32768, -32768, -32768, -32768));
        seg_pending.push_back(seg_pair(32767, 32767, 32767, 32767,
                                       32767, 32767, 32767, 32767));
        // widest crossing: diagonals of the full square
        seg_pending.push_back(seg_pair(-32768, -32768, 32767, 32767,
                                       -32768, 32767, 32767, -32768));
        seg_pending.push_back(seg_pair(-32768, 32767, 32767, -32768,
                                       32767, 32767, -32768, -32768));
        // plain bounded crossing and crossing at an end point
        seg_pending.push_back(seg_pair(0, 0, 10, 10, 0, 10, 10, 0));
        seg_pending.push_back(seg_pair(0, 0, 10, 0, 10, 0, 10, 10));
        seg_pending.push_back(seg_pair(0, 0, 10, 0, 0, 0, 0, 10));
        // unbounded: lines cross beyond the segments
        seg_pending.push_back(seg_pair(0, 0, 1, 0, 5, 5, 5, 6));
        seg_pending.push_back(seg_pair(0, 0, 3, 1, -7, 2, -7, 9));
        // parallel, collinear, and a zero-length segment
        seg_pending.push_back(seg_pair(0, 0, 5, 5, 1, 0, 6, 5));
        seg_pending.push_back(seg_pair(0, 0, 5, 5, 2, 2, 9, 9));
        seg_pending.push_back(seg_pair(3, 3, 3, 3, 0, 0, 5, 1));
        // non-integer point, truncation toward zero on both signs
        seg_pending.push_back(seg_pair(0, 0, 3, 1, 1, 0, 0, 3));
        seg_pending.push_back(seg_pair(0, 0, -3, -1, -1, 0, 0, -3));
        // nearly parallel: clamps high and low, last one meets at an end point
        seg_pending.push_back(seg_pair(0, 0, 32767, 1, 0, 1, 32766, 2));
        seg_pending.push_back(seg_pair(0, 0, -32768, 1, 0, 1, -32767, 2));
        seg_pending.push_back(seg_pair(-32768, -32768, 32767, -32767,
                                       -32768, -32767, 32767, -32767));
        for (int i = 0; i < NumRandom; i++) begin
            seg_pending.push_back(random_pair());
        end
        words_total = seg_pending.size();
    end

    // sender: offers pending words, random idle bursts except near the end
    int in_gap;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            i_in_word  <= '0;
            in_gap     <= 0;
        end else if (!(i_in_valid && !o_in_ready)) begin
            if (i_in_valid) begin
                crossing_expected.push_back(predict_crossing(i_in_word));
                words_sent <= words_sent + 1;
            end
            if (in_gap > 0) begin
                in_gap     <= in_gap - 1;
                i_in_valid <= 1'b0;
            end else if (seg_pending.size() > 0) begin
                i_in_valid <= 1'b1;
                i_in_word  <= seg_pending.pop_front();
                if (seg_pending.size() > CalmTail && $urandom_range(9) == 0) begin
                    in_gap <= $urandom_range(1, 18);
                end
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // receiver: checks every crossing word, stalls in bursts, one long hold-off
    int out_stall;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            out_stall   <= 0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                words_seen <= words_seen + 1;
                if (crossing_expected.size() == 0) begin
                    $display("%0t: unexpected word %p", $realtime, o_out_word);
                    fail_count <= fail_count + 1;
                end else begin
                    sit_pkg::t_isect_word exp_w;
                    exp_w = crossing_expected.pop_front();
                    if (exp_w !== o_out_word) begin
                        $display("%0t: mismatch expected %p actual %p",
                                 $realtime, exp_w, o_out_word);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (out_stall > 0) begin
                out_stall   <= out_stall - 1;
                i_out_ready <= 1'b0;
            end else if (!hold_done && words_sent > 200) begin
                // long hold-off while the sender keeps offering: pipeline fills
                hold_done   <= 1'b1;
                out_stall   <= LongHold;
                i_out_ready <= 1'b0;
            end else if (seg_pending.size() > CalmTail && $urandom_range(9) == 0) begin
                out_stall   <= $urandom_range(1, 18) - 1;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CycleLimit) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        i_rst_n = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        while (words_seen < words_total) begin
            @(posedge i_clk);
        end
        repeat (DrainCycles) @(posedge i_clk);
        if (fail_count == 0 && crossing_expected.size() == 0 &&
            words_seen == words_total) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

### segment_intersection_test.f
design/sit_pkg.sv
design/sit_front.sv
design/sit_div.sv
design/segment_intersection_test.sv
bench/tb.sv
